@@ rtl/core/qrs_pkg.sv @@
// Shared constants and types for the quadratic root solver.
// Used by qrs_sqrt, qrs_div, quadratic_root_solver and its testbench; depends on nothing.
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int ROOT_W   = 32;
    localparam int KIND_W   = 3;
    localparam int RAD_W    = 64;
    localparam int SQRT_W   = RAD_W / 2;
    localparam int SREM_W   = SQRT_W + 2;
    localparam int NUM_W    = 34;
    localparam int SNUM_W   = NUM_W + 1;
    localparam int DEN_W    = COEF_W;

    localparam logic [KIND_W-1:0] KIND_TWO    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LINEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEGEN  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } sq_tag_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              neg_one;
        logic              neg_two;
    } div_tag_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [ROOT_W-1:0] root_one;
        logic signed [ROOT_W-1:0] root_two;
        logic                     sat;
    } result_t;

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// Real roots of a*x^2 + b*x + c = 0, Q8.8 coefficients in, Q16.16 roots out.
// An accepted beat passes two front stages, 32 square-root stages, two numerator
// stages, 34 divider stages and the output register. Throughput is one beat per
// cycle while in_stall is low; a two-entry output register and skid buffer decouple
// the sides. Reset clears every valid bit; the block is ready straight after reset.
module quadratic_root_solver import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [KIND_W-1:0]        root_kind,
    output logic signed [ROOT_W-1:0] root_one,
    output logic signed [ROOT_W-1:0] root_two,
    output logic                     saturated
);

    logic adv;

    logic                       v1_reg;
    logic signed [COEF_W-1:0]   a1_reg, b1_reg, c1_reg;
    logic signed [2*COEF_W-1:0] bb1_reg, ac1_reg;

    logic                       v2_reg;
    logic [RAD_W-1:0]           rad2_reg;
    sq_tag_t                    tag2_reg;
    logic signed [2*COEF_W+1:0] d_next;
    logic [KIND_W-1:0]          kind_next;

    logic              sq_vld;
    logic [SQRT_W-1:0] sq_root;
    sq_tag_t           sq_tag;

    logic                     v3_reg;
    logic signed [SNUM_W-1:0] n1_reg, n2_reg;
    logic signed [DEN_W-1:0]  den3_reg;
    logic [KIND_W-1:0]        kind3_reg;
    logic signed [SNUM_W-1:0] n1_next, n2_next;
    logic signed [DEN_W-1:0]  den_next;

    logic             v4_reg;
    logic [NUM_W-1:0] m1_reg, m2_reg;
    logic [DEN_W-1:0] ud4_reg;
    div_tag_t         tag4_reg;
    logic [DEN_W-1:0] ud_next;
    logic [SNUM_W-1:0] half;

    logic             dv_vld;
    logic [NUM_W-1:0] q1, q2;
    div_tag_t         dv_tag;

    logic signed [SNUM_W-1:0] s1, s2;
    logic                     c1_hi, c1_lo, c2_hi, c2_lo;
    result_t                  res_next;

    logic    out_vld_reg, skid_vld_reg;
    result_t out_reg, skid_reg;

    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= sq_vld;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        d_next = (2*COEF_W+2)'(bb1_reg) - ((2*COEF_W+2)'(ac1_reg) <<< 2);
        priority if (a1_reg == '0)
        begin
            kind_next = (b1_reg == '0) ? KIND_DEGEN : KIND_LINEAR;
        end
        else if (d_next > 0)
        begin
            kind_next = KIND_TWO;
        end
        else if (d_next == 0)
        begin
            kind_next = KIND_DOUBLE;
        end
        else
        begin
            kind_next = KIND_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            bb1_reg  <= coef_b * coef_b;
            ac1_reg  <= coef_a * coef_c;
            rad2_reg <= (kind_next == KIND_TWO) ? {1'b0, d_next[32:0], 30'b0} : '0;
            tag2_reg <= '{kind: kind_next, a: a1_reg, b: b1_reg, c: c1_reg};
        end
    end

    qrs_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (v2_reg),
        .in_rad   (rad2_reg),
        .in_tag   (tag2_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_tag  (sq_tag)
    );

    always_comb
    begin
        n1_next  = '0;
        n2_next  = '0;
        den_next = DEN_W'(1);
        unique case (sq_tag.kind)
            KIND_TWO:
            begin
                n1_next  = -(SNUM_W'(sq_tag.b) <<< 15) + SNUM_W'(sq_root);
                n2_next  = -(SNUM_W'(sq_tag.b) <<< 15) - SNUM_W'(sq_root);
                den_next = sq_tag.a;
            end
            KIND_DOUBLE:
            begin
                n1_next  = -(SNUM_W'(sq_tag.b) <<< 15);
                den_next = sq_tag.a;
            end
            KIND_LINEAR:
            begin
                n1_next  = -(SNUM_W'(sq_tag.c) <<< 16);
                den_next = sq_tag.b;
            end
            default:
            begin
                n1_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        ud_next = den3_reg[DEN_W-1] ? DEN_W'(-den3_reg) : DEN_W'(den3_reg);
        half    = SNUM_W'(ud_next >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            den3_reg  <= den_next;
            kind3_reg <= sq_tag.kind;
            m1_reg    <= n1_reg[SNUM_W-1] ? NUM_W'(half - n1_reg) : NUM_W'(n1_reg + half);
            m2_reg    <= n2_reg[SNUM_W-1] ? NUM_W'(half - n2_reg) : NUM_W'(n2_reg + half);
            ud4_reg   <= ud_next;
            tag4_reg  <= '{kind:    kind3_reg,
                           neg_one: n1_reg[SNUM_W-1] ^ den3_reg[DEN_W-1],
                           neg_two: n2_reg[SNUM_W-1] ^ den3_reg[DEN_W-1]};
        end
    end

    qrs_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_vld      (v4_reg),
        .in_num_one  (m1_reg),
        .in_num_two  (m2_reg),
        .in_den      (ud4_reg),
        .in_tag      (tag4_reg),
        .out_vld     (dv_vld),
        .out_quo_one (q1),
        .out_quo_two (q2),
        .out_tag     (dv_tag)
    );

    always_comb
    begin
        s1    = dv_tag.neg_one ? -SNUM_W'(q1) : SNUM_W'(q1);
        s2    = dv_tag.neg_two ? -SNUM_W'(q2) : SNUM_W'(q2);
        c1_hi = s1 > $signed(SNUM_W'({1'b0, {(ROOT_W-1){1'b1}}}));
        c1_lo = s1 < -$signed(SNUM_W'({1'b1, {(ROOT_W-1){1'b0}}}));
        c2_hi = s2 > $signed(SNUM_W'({1'b0, {(ROOT_W-1){1'b1}}}));
        c2_lo = s2 < -$signed(SNUM_W'({1'b1, {(ROOT_W-1){1'b0}}}));
        res_next.kind     = dv_tag.kind;
        res_next.root_one = '0;
        res_next.root_two = '0;
        res_next.sat      = 1'b0;
        if (dv_tag.kind == KIND_TWO || dv_tag.kind == KIND_DOUBLE
            || dv_tag.kind == KIND_LINEAR)
        begin
            res_next.root_one = c1_hi ? {1'b0, {(ROOT_W-1){1'b1}}}
                              : c1_lo ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(s1);
            res_next.sat      = c1_hi | c1_lo;
        end
        if (dv_tag.kind == KIND_TWO)
        begin
            res_next.root_two = c2_hi ? {1'b0, {(ROOT_W-1){1'b1}}}
                              : c2_lo ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(s2);
            res_next.sat      = c1_hi | c1_lo | c2_hi | c2_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (!out_stall)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (dv_vld)
        begin
            if (out_vld_reg && out_stall)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (!out_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (dv_vld)
        begin
            if (out_vld_reg && out_stall)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign root_kind = out_reg.kind;
    assign root_one  = out_reg.root_one;
    assign root_two  = out_reg.root_two;
    assign saturated = out_reg.sat;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid buffer holds a beat while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_stall) && $past(out_vld_reg))
        else $error("skid buffer filled without a stalled output");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_NONE || root_kind == KIND_DEGEN)
        |-> root_one == '0 && root_two == '0 && !saturated)
        else $error("roots reported for an equation without real roots");

    a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_DOUBLE || root_kind == KIND_LINEAR)
        |-> root_two == '0)
        else $error("second root reported for a single-root result");

endmodule

@@ rtl/core/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg for widths and the tag type that travels alongside.
module qrs_sqrt import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [RAD_W-1:0]  in_rad,
    input  sq_tag_t           in_tag,
    output logic              out_vld,
    output logic [SQRT_W-1:0] out_root,
    output sq_tag_t           out_tag
);

    logic              vld_reg  [1:SQRT_W];
    logic [RAD_W-1:0]  rad_reg  [1:SQRT_W];
    logic [SREM_W-1:0] rem_reg  [1:SQRT_W];
    logic [SQRT_W-1:0] root_reg [1:SQRT_W];
    sq_tag_t           tag_reg  [1:SQRT_W];

    for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
        logic              vld_i;
        logic [RAD_W-1:0]  rad_i;
        logic [SREM_W-1:0] rem_i;
        logic [SQRT_W-1:0] root_i;
        sq_tag_t           tag_i;
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;
        logic              ge;
        logic [SREM_W-1:0] rem_next;
        logic [SQRT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign vld_i  = in_vld;
            assign rad_i  = in_rad;
            assign rem_i  = '0;
            assign root_i = '0;
            assign tag_i  = in_tag;
        end
        else begin : g_rest
            assign vld_i  = vld_reg[k];
            assign rad_i  = rad_reg[k];
            assign rem_i  = rem_reg[k];
            assign root_i = root_reg[k];
            assign tag_i  = tag_reg[k];
        end

        always_comb
        begin
            rem_sh    = {rem_i[SREM_W-3:0], rad_i[RAD_W-1 -: 2]};
            trial     = {root_i, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_i[SQRT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1]  <= {rad_i[RAD_W-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                tag_reg[k+1]  <= tag_i;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_W];
    assign out_root = root_reg[SQRT_W];
    assign out_tag  = tag_reg[SQRT_W];

endmodule

@@ rtl/core/qrs_div.sv @@
// Pipelined restoring divider for two numerators over one shared divisor.
// Depends on qrs_pkg for widths and the tag type that travels alongside.
module qrs_div import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] in_num_one,
    input  logic [NUM_W-1:0] in_num_two,
    input  logic [DEN_W-1:0] in_den,
    input  div_tag_t         in_tag,
    output logic             out_vld,
    output logic [NUM_W-1:0] out_quo_one,
    output logic [NUM_W-1:0] out_quo_two,
    output div_tag_t         out_tag
);

    logic             vld_reg  [1:NUM_W];
    logic [NUM_W-1:0] n1_reg   [1:NUM_W];
    logic [NUM_W-1:0] n2_reg   [1:NUM_W];
    logic [DEN_W-1:0] r1_reg   [1:NUM_W];
    logic [DEN_W-1:0] r2_reg   [1:NUM_W];
    logic [DEN_W-1:0] den_reg  [1:NUM_W];
    div_tag_t         tag_reg  [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             vld_i;
        logic [NUM_W-1:0] n1_i;
        logic [NUM_W-1:0] n2_i;
        logic [DEN_W-1:0] r1_i;
        logic [DEN_W-1:0] r2_i;
        logic [DEN_W-1:0] den_i;
        div_tag_t         tag_i;
        logic [DEN_W:0]   sh1;
        logic [DEN_W:0]   sh2;
        logic             ge1;
        logic             ge2;
        logic [DEN_W-1:0] r1_next;
        logic [DEN_W-1:0] r2_next;

        if (k == 0) begin : g_first
            assign vld_i = in_vld;
            assign n1_i  = in_num_one;
            assign n2_i  = in_num_two;
            assign r1_i  = '0;
            assign r2_i  = '0;
            assign den_i = in_den;
            assign tag_i = in_tag;
        end
        else begin : g_rest
            assign vld_i = vld_reg[k];
            assign n1_i  = n1_reg[k];
            assign n2_i  = n2_reg[k];
            assign r1_i  = r1_reg[k];
            assign r2_i  = r2_reg[k];
            assign den_i = den_reg[k];
            assign tag_i = tag_reg[k];
        end

        always_comb
        begin
            sh1     = {r1_i, n1_i[NUM_W-1]};
            sh2     = {r2_i, n2_i[NUM_W-1]};
            ge1     = (sh1 >= {1'b0, den_i});
            ge2     = (sh2 >= {1'b0, den_i});
            r1_next = ge1 ? DEN_W'(sh1 - {1'b0, den_i}) : sh1[DEN_W-1:0];
            r2_next = ge2 ? DEN_W'(sh2 - {1'b0, den_i}) : sh2[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n1_reg[k+1]  <= {n1_i[NUM_W-2:0], ge1};
                n2_reg[k+1]  <= {n2_i[NUM_W-2:0], ge2};
                r1_reg[k+1]  <= r1_next;
                r2_reg[k+1]  <= r2_next;
                den_reg[k+1] <= den_i;
                tag_reg[k+1] <= tag_i;
            end
        end
    end

    assign out_vld     = vld_reg[NUM_W];
    assign out_quo_one = n1_reg[NUM_W];
    assign out_quo_two = n2_reg[NUM_W];
    assign out_tag     = tag_reg[NUM_W];

endmodule

@@ bench/tb_quadratic_root_solver.sv @@
// Self-checking testbench for quadratic_root_solver: drives coefficient beats and checks
// each root beat against a built-in fixed-point solver, with random idling on both sides.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic                     out_valid;
    logic                     out_stall;
    logic [KIND_W-1:0]        root_kind;
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;
    logic                     saturated;

    result_t expected_roots[$];
    int      mismatch_count;
    bit      idling_on;

    quadratic_root_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root_kind (root_kind),
        .root_one  (root_one),
        .root_two  (root_two),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned probe;
        r = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= r + probe)
            begin
                v = v - (r + probe);
                r = (r >> 1) + probe;
            end
            else
            begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    function automatic longint round_quotient(longint n, longint d);
        bit              neg;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? longint'(-n) : longint'(n);
        ud = (d < 0) ? longint'(-d) : longint'(d);
        q = (un + ud / 2) / ud;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [ROOT_W-1:0] clip_root(longint v, inout logic clipped);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ROOT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            v = hi;
            clipped = 1'b1;
        end
        else if (v < lo)
        begin
            v = lo;
            clipped = 1'b1;
        end
        return v[ROOT_W-1:0];
    endfunction

    function automatic result_t solve_roots(logic signed [COEF_W-1:0] ca,
                                            logic signed [COEF_W-1:0] cb,
                                            logic signed [COEF_W-1:0] cc);
        result_t res;
        longint  a;
        longint  b;
        longint  c;
        longint  disc;
        longint  s;
        longint  nb;
        a = ca;
        b = cb;
        c = cc;
        res = '0;
        if (a == 0)
        begin
            if (b == 0)
            begin
                res.kind = KIND_DEGEN;
            end
            else
            begin
                res.kind = KIND_LINEAR;
                res.root_one = clip_root(round_quotient(-c * 65536, b), res.sat);
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            nb = -b * 32768;
            if (disc > 0)
            begin
                s = longint'(int_sqrt(longint'(disc) << 30));
                res.kind = KIND_TWO;
                res.root_one = clip_root(round_quotient(nb + s, a), res.sat);
                res.root_two = clip_root(round_quotient(nb - s, a), res.sat);
            end
            else if (disc == 0)
            begin
                res.kind = KIND_DOUBLE;
                res.root_one = clip_root(round_quotient(nb, a), res.sat);
            end
            else
            begin
                res.kind = KIND_NONE;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                              logic signed [COEF_W-1:0] c);
        logic stalled;
        while (idling_on && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        expected_roots.push_back(solve_roots(a, b, c));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= idling_on && ($urandom_range(0, 99) < 8);
    end

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_roots.size() == 0)
            begin
                report_mismatch("unexpected beat, root_kind", root_kind, -1);
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root_kind !== want.kind)
                    report_mismatch("root_kind", root_kind, want.kind);
                if (root_one !== want.root_one)
                    report_mismatch("root_one", root_one, want.root_one);
                if (root_two !== want.root_two)
                    report_mismatch("root_two", root_two, want.root_two);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
        end
    end

    task automatic test_directed();
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh0000, 16'sh0000, 16'sh0000);
        send_coefs(16'sh0000, 16'sh0000, 16'sh7fff);
        send_coefs(16'sh0000, 16'sh0100, 16'sh0200);
        send_coefs(16'sh0000, 16'sh0001, 16'sh8000);
        send_coefs(16'sh0000, 16'shffff, 16'sh7fff);
        send_coefs(16'sh0000, 16'sh8000, 16'sh8000);
        send_coefs(16'sh0100, 16'sh0200, 16'sh0100);
        send_coefs(16'sh0001, 16'sh7ffe, 16'sh3fff);
        send_coefs(16'shff00, 16'sh0200, 16'shff00);
        send_coefs(16'sh0100, 16'sh0000, 16'sh0100);
        send_coefs(16'sh8000, 16'sh0000, 16'sh8000);
        send_coefs(16'sh0100, 16'sh0000, 16'shff00);
        send_coefs(16'sh0001, 16'sh8000, 16'sh0000);
        send_coefs(16'shffff, 16'sh7fff, 16'sh0000);
        send_coefs(16'sh0001, 16'sh0003, 16'sh0001);
        send_coefs(16'sh0002, 16'sh0001, 16'sh0000);
    endtask

    task automatic test_random_full(int count);
        repeat (count)
            send_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic test_random_small(int count);
        repeat (count)
            send_coefs(COEF_W'($urandom_range(0, 1023) - 512),
                       COEF_W'($urandom_range(0, 1023) - 512),
                       COEF_W'($urandom_range(0, 1023) - 512));
    endtask

    task automatic test_random_linear(int count);
        repeat (count)
            send_coefs(16'sh0000,
                       COEF_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom),
                       COEF_W'($urandom));
    endtask

    task automatic test_random_double(int count);
        int p;
        int q;
        int g;
        repeat (count)
        begin
            p = $urandom_range(1, 127);
            q = $urandom_range(0, 127);
            g = $urandom_range(0, 1) ? 1 : -1;
            send_coefs(COEF_W'(g * p * p),
                       COEF_W'(($urandom_range(0, 1) ? 2 : -2) * g * p * q),
                       COEF_W'(g * q * q));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        coef_a         = '0;
        coef_b         = '0;
        coef_c         = '0;
        mismatch_count = 0;
        idling_on      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_full(700);
        idling_on = 1'b0;
        test_random_full(300);
        idling_on = 1'b1;
        test_random_small(350);
        test_random_linear(250);
        test_random_double(250);
        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_roots.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ quadratic_root_solver.f @@
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
bench/tb_quadratic_root_solver.sv
